FILE: hdl/bamp_pkg.sv
// ----------------------------------------------------------------------------
// bamp_pkg
// Shared types, register map, reset values and Q16.16 helpers for the box
// anchor motion projection unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bamp_pkg;

    // Register map, one 64-bit slot per register (byte address 8*index)
    typedef enum logic [2:0] {
        REG_ROW0_FIRST  = 3'd0,
        REG_ROW0_SECOND = 3'd1,
        REG_ROW1_FIRST  = 3'd2,
        REG_ROW1_SECOND = 3'd3,
        REG_ROW2_FIRST  = 3'd4,
        REG_ROW2_SECOND = 3'd5,
        REG_TIME_STEP   = 3'd6
    } t_reg_idx;

    localparam logic [63:0] RST_ROW0_FIRST  = 64'h0001_0000_0000_0000;
    localparam logic [63:0] RST_ROW0_SECOND = 64'h0;
    localparam logic [63:0] RST_ROW1_FIRST  = 64'h0000_0000_0001_0000;
    localparam logic [63:0] RST_ROW1_SECOND = 64'h0;
    localparam logic [63:0] RST_ROW2_FIRST  = 64'h0;
    localparam logic [63:0] RST_ROW2_SECOND = 64'h0001_0000_0000_0000;
    localparam logic [31:0] RST_TIME_STEP   = 32'h0;

    // One anchor word; also used for the result word
    typedef struct packed {
        logic [31:0] center_x;
        logic [31:0] center_y;
        logic [31:0] center_z;
        logic [31:0] size_w;
        logic [31:0] size_l;
        logic [31:0] size_h;
        logic [31:0] yaw_a;
        logic [31:0] yaw_b;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic        last;
    } t_anchor;

    // Transform coefficients m[row][k] (k = 3..1 scale x, y, z; k = 0 is translation) and time step
    typedef struct packed {
        logic [2:0][3:0][31:0] m;
        logic [31:0]           dt;
    } t_xform_cfg;

    // Q16.16 product, floor-shifted by 16
    function automatic logic signed [47:0] qmul(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] p;
        p = $signed(a) * $signed(b);
        return p[63:16];
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        logic [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bamp_cfg_regs.sv
// ----------------------------------------------------------------------------
// bamp_cfg_regs
// APB register file holding the 3x4 transform and the frame time step.
// ----------------------------------------------------------------------------
`default_nettype none

module bamp_cfg_regs (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_psel,
    input  wire logic                 i_penable,
    input  wire logic                 i_pwrite,
    input  wire logic [5:0]           i_paddr,
    input  wire logic [63:0]          i_pwdata,
    output logic      [63:0]          o_prdata,
    output logic                      o_pready,
    output bamp_pkg::t_xform_cfg      o_cfg
);

    logic [63:0] r_row0_first, r_row0_second;
    logic [63:0] r_row1_first, r_row1_second;
    logic [63:0] r_row2_first, r_row2_second;
    logic [31:0] r_time_step;

    bamp_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign w_idx    = bamp_pkg::t_reg_idx'(i_paddr[5:3]);
    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0_first  <= bamp_pkg::RST_ROW0_FIRST;
            r_row0_second <= bamp_pkg::RST_ROW0_SECOND;
            r_row1_first  <= bamp_pkg::RST_ROW1_FIRST;
            r_row1_second <= bamp_pkg::RST_ROW1_SECOND;
            r_row2_first  <= bamp_pkg::RST_ROW2_FIRST;
            r_row2_second <= bamp_pkg::RST_ROW2_SECOND;
            r_time_step   <= bamp_pkg::RST_TIME_STEP;
        end else if (w_wr) begin
            unique case (w_idx)
                bamp_pkg::REG_ROW0_FIRST:  r_row0_first  <= i_pwdata;
                bamp_pkg::REG_ROW0_SECOND: r_row0_second <= i_pwdata;
                bamp_pkg::REG_ROW1_FIRST:  r_row1_first  <= i_pwdata;
                bamp_pkg::REG_ROW1_SECOND: r_row1_second <= i_pwdata;
                bamp_pkg::REG_ROW2_FIRST:  r_row2_first  <= i_pwdata;
                bamp_pkg::REG_ROW2_SECOND: r_row2_second <= i_pwdata;
                bamp_pkg::REG_TIME_STEP:   r_time_step   <= i_pwdata[31:0];
                default: ; // unmapped slot: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            bamp_pkg::REG_ROW0_FIRST:  o_prdata = r_row0_first;
            bamp_pkg::REG_ROW0_SECOND: o_prdata = r_row0_second;
            bamp_pkg::REG_ROW1_FIRST:  o_prdata = r_row1_first;
            bamp_pkg::REG_ROW1_SECOND: o_prdata = r_row1_second;
            bamp_pkg::REG_ROW2_FIRST:  o_prdata = r_row2_first;
            bamp_pkg::REG_ROW2_SECOND: o_prdata = r_row2_second;
            bamp_pkg::REG_TIME_STEP:   o_prdata = {32'h0, r_time_step};
            default:                   o_prdata = 64'h0;
        endcase
    end

    always_comb begin
        o_cfg.m[0] = {r_row0_first[63:32], r_row0_first[31:0],
                      r_row0_second[63:32], r_row0_second[31:0]};
        o_cfg.m[1] = {r_row1_first[63:32], r_row1_first[31:0],
                      r_row1_second[63:32], r_row1_second[31:0]};
        o_cfg.m[2] = {r_row2_first[63:32], r_row2_first[31:0],
                      r_row2_second[63:32], r_row2_second[31:0]};
        o_cfg.dt   = r_time_step;
    end

endmodule

`default_nettype wire

FILE: hdl/bamp_advance.sv
// ----------------------------------------------------------------------------
// bamp_advance
// Two pipeline stages that move the anchor center by velocity times dt:
// multiply and floor-shift, then add and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module bamp_advance (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire bamp_pkg::t_anchor i_anchor,
    input  wire logic [31:0]       i_dt,
    output logic                   o_valid,
    output bamp_pkg::t_anchor      o_anchor
);

    logic [2:0][31:0]         w_vel;
    logic signed [32:0]       w_dt;
    logic signed [64:0]       w_prod [3];
    logic signed [48:0]       n_s1_step [3];

    logic                     r_s1_valid;
    bamp_pkg::t_anchor        r_s1_anchor;
    logic signed [48:0]       r_s1_step [3];

    logic [2:0][31:0]         w_ctr;
    logic [31:0]              n_s2_ctr [3];
    bamp_pkg::t_anchor        n_s2_anchor;
    logic                     r_s2_valid;
    bamp_pkg::t_anchor        r_s2_anchor;

    assign w_vel = {i_anchor.vel_x, i_anchor.vel_y, i_anchor.vel_z};
    assign w_dt  = $signed({1'b0, i_dt});

    // Stage 1: v * dt, keep the floor of the Q16.16 product
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_prod[k]    = 65'($signed(w_vel[2-k])) * 65'(w_dt);
            n_s1_step[k] = w_prod[k][64:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_anchor <= i_anchor;
        r_s1_step   <= n_s1_step;
    end

    // Stage 2: c + step, clamp before the transform
    assign w_ctr = {r_s1_anchor.center_x, r_s1_anchor.center_y, r_s1_anchor.center_z};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s2_ctr[k] = bamp_pkg::sat32(64'($signed(w_ctr[2-k])) + 64'(r_s1_step[k]));
        end
        n_s2_anchor          = r_s1_anchor;
        n_s2_anchor.center_x = n_s2_ctr[0];
        n_s2_anchor.center_y = n_s2_ctr[1];
        n_s2_anchor.center_z = n_s2_ctr[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_anchor <= n_s2_anchor;
    end

    assign o_valid  = r_s2_valid;
    assign o_anchor = r_s2_anchor;

endmodule

`default_nettype wire

FILE: hdl/bamp_xform.sv
// ----------------------------------------------------------------------------
// bamp_xform
// Two pipeline stages applying the rigid transform: all coefficient products
// in parallel, then per-row sums with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module bamp_xform (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire bamp_pkg::t_anchor    i_anchor,
    input  wire bamp_pkg::t_xform_cfg i_cfg,
    output logic                      o_valid,
    output bamp_pkg::t_anchor         o_result
);

    logic [2:0][31:0]   w_ctr;
    logic [2:0][31:0]   w_vel;

    logic signed [47:0] n_pc [3][3];
    logic signed [47:0] n_pv [3][3];
    logic signed [47:0] n_py [2][2];

    logic               r_s3_valid;
    bamp_pkg::t_anchor  r_s3_anchor;
    logic signed [47:0] r_pc [3][3];
    logic signed [47:0] r_pv [3][3];
    logic signed [47:0] r_py [2][2];

    logic [31:0]        n_oc [3];
    logic [31:0]        n_ov [3];
    logic [31:0]        n_oy [2];

    logic               r_s4_valid;
    bamp_pkg::t_anchor  r_s4_result;

    assign w_ctr = {i_anchor.center_x, i_anchor.center_y, i_anchor.center_z};
    assign w_vel = {i_anchor.vel_x, i_anchor.vel_y, i_anchor.vel_z};

    // Stage 3: every product of the matrix with center, velocity and yaw
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_pc[r][c] = bamp_pkg::qmul(i_cfg.m[r][3-c], w_ctr[2-c]);
                n_pv[r][c] = bamp_pkg::qmul(i_cfg.m[r][3-c], w_vel[2-c]);
            end
        end
        // yaw pair enters swapped: b pairs with m[r][3] (the x coefficient), a with m[r][2]
        for (int r = 0; r < 2; r++) begin
            n_py[r][0] = bamp_pkg::qmul(i_cfg.m[r][3], i_anchor.yaw_b);
            n_py[r][1] = bamp_pkg::qmul(i_cfg.m[r][2], i_anchor.yaw_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_anchor <= i_anchor;
        r_pc        <= n_pc;
        r_pv        <= n_pv;
        r_py        <= n_py;
    end

    // Stage 4: exact row sums, one clamp at the end
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_oc[r] = bamp_pkg::sat32(64'(r_pc[r][0]) + 64'(r_pc[r][1]) + 64'(r_pc[r][2])
                                      + 64'($signed(i_cfg.m[r][0])));
            n_ov[r] = bamp_pkg::sat32(64'(r_pv[r][0]) + 64'(r_pv[r][1]) + 64'(r_pv[r][2]));
        end
        for (int r = 0; r < 2; r++) begin
            n_oy[r] = bamp_pkg::sat32(64'(r_py[r][0]) + 64'(r_py[r][1]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_result.center_x <= n_oc[0];
        r_s4_result.center_y <= n_oc[1];
        r_s4_result.center_z <= n_oc[2];
        r_s4_result.size_w   <= r_s3_anchor.size_w;
        r_s4_result.size_l   <= r_s3_anchor.size_l;
        r_s4_result.size_h   <= r_s3_anchor.size_h;
        r_s4_result.yaw_a    <= n_oy[0];
        r_s4_result.yaw_b    <= n_oy[1];
        r_s4_result.vel_x    <= n_ov[0];
        r_s4_result.vel_y    <= n_ov[1];
        r_s4_result.vel_z    <= n_ov[2];
        r_s4_result.last     <= r_s3_anchor.last;
    end

    assign o_valid  = r_s4_valid;
    assign o_result = r_s4_result;

endmodule

`default_nettype wire

FILE: hdl/box_anchor_motion_projection_unit.sv
// ----------------------------------------------------------------------------
// box_anchor_motion_projection_unit
// Advances a 3D box anchor by velocity * dt, then maps center, velocity and
// yaw pair through a configured rigid transform (signed Q16.16).
//
//   Channel   Ports                          Handshake
//   -------   -----------------------------  ------------------------------
//   anchor    i_center_x .. i_last_anchor    start && !busy
//   result    o_out_center_x .. o_out_last   o_valid, one-cycle strobe
//   config    psel penable pwrite paddr ...  APB, pready tied high
//
// One word enters per cycle; busy is always low.
// Pipeline stages, in order: v*dt multiply, center add/clamp, matrix products,
// row sums with clamp. The 32x32 multipliers set the stage depth.
// Reset clears only the valid bits and loads the identity transform, dt = 0.
// Results cannot be held off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module box_anchor_motion_projection_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_center_x,
    input  wire logic [31:0] i_center_y,
    input  wire logic [31:0] i_center_z,
    input  wire logic [31:0] i_size_w,
    input  wire logic [31:0] i_size_l,
    input  wire logic [31:0] i_size_h,
    input  wire logic [31:0] i_yaw_a,
    input  wire logic [31:0] i_yaw_b,
    input  wire logic [31:0] i_vel_x,
    input  wire logic [31:0] i_vel_y,
    input  wire logic [31:0] i_vel_z,
    input  wire logic        i_last_anchor,

    output logic             o_valid,
    output logic [31:0]      o_out_center_x,
    output logic [31:0]      o_out_center_y,
    output logic [31:0]      o_out_center_z,
    output logic [31:0]      o_out_size_w,
    output logic [31:0]      o_out_size_l,
    output logic [31:0]      o_out_size_h,
    output logic [31:0]      o_out_yaw_first,
    output logic [31:0]      o_out_yaw_second,
    output logic [31:0]      o_out_vel_x,
    output logic [31:0]      o_out_vel_y,
    output logic [31:0]      o_out_vel_z,
    output logic             o_out_last,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    bamp_pkg::t_xform_cfg w_cfg;
    bamp_pkg::t_anchor    w_in;
    logic                 w_in_valid;
    logic                 w_adv_valid;
    bamp_pkg::t_anchor    w_adv;
    logic                 w_res_valid;
    bamp_pkg::t_anchor    w_res;

    assign busy       = 1'b0;
    assign w_in_valid = start && !busy;

    always_comb begin
        w_in.center_x = i_center_x;
        w_in.center_y = i_center_y;
        w_in.center_z = i_center_z;
        w_in.size_w   = i_size_w;
        w_in.size_l   = i_size_l;
        w_in.size_h   = i_size_h;
        w_in.yaw_a    = i_yaw_a;
        w_in.yaw_b    = i_yaw_b;
        w_in.vel_x    = i_vel_x;
        w_in.vel_y    = i_vel_y;
        w_in.vel_z    = i_vel_z;
        w_in.last     = i_last_anchor;
    end

    bamp_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    bamp_advance u_advance (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_in_valid),
        .i_anchor (w_in),
        .i_dt     (w_cfg.dt),
        .o_valid  (w_adv_valid),
        .o_anchor (w_adv)
    );

    bamp_xform u_xform (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_adv_valid),
        .i_anchor (w_adv),
        .i_cfg    (w_cfg),
        .o_valid  (w_res_valid),
        .o_result (w_res)
    );

    assign o_valid          = w_res_valid;
    assign o_out_center_x   = w_res.center_x;
    assign o_out_center_y   = w_res.center_y;
    assign o_out_center_z   = w_res.center_z;
    assign o_out_size_w     = w_res.size_w;
    assign o_out_size_l     = w_res.size_l;
    assign o_out_size_h     = w_res.size_h;
    assign o_out_yaw_first  = w_res.yaw_a;
    assign o_out_yaw_second = w_res.yaw_b;
    assign o_out_vel_x      = w_res.vel_x;
    assign o_out_vel_y      = w_res.vel_y;
    assign o_out_vel_z      = w_res.vel_z;
    assign o_out_last       = w_res.last;

    // Every accepted word yields exactly one strobe once it leaves the stage 4 register
    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##4 o_valid)
        else $error("accepted word produced no result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##4 !o_valid)
        else $error("result strobe without an accepted word");

    a_size_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_size_w == $past(i_size_w, 4))
                 && (o_out_last == $past(i_last_anchor, 4)))
        else $error("size or last mark misaligned with its word");

endmodule

`default_nettype wire
